### src/ukos_pkg.sv
// shared types and codes for the unique key ordered set
`default_nettype none

package ukos_pkg;

	// operation codes
	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_FIND  = 3'd1;
	localparam logic [2:0] OP_REMK  = 3'd2;
	localparam logic [2:0] OP_REMI  = 3'd3;
	localparam logic [2:0] OP_POP   = 3'd4;
	localparam logic [2:0] OP_READ  = 3'd5;
	localparam logic [2:0] OP_CLEAR = 3'd6;

	// result status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_MISS  = 3'd1;
	localparam logic [2:0] ST_DUP   = 3'd2;
	localparam logic [2:0] ST_FULL  = 3'd3;
	localparam logic [2:0] ST_ZERO  = 3'd4;
	localparam logic [2:0] ST_RANGE = 3'd5;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] key;
		logic [3:0]  position;
	} req_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] key_out;
		logic [3:0]  found_index;
		logic [4:0]  entry_count;
		logic        is_empty;
	} rsp_item_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       idx_zero;
		logic       idx_pos;
		logic       idx_last;
		logic       idx_inc;
		logic       rd_en;
		logic       rd_next;
		logic       sh_wr;
		logic       append;
		logic       vacate;
		logic       pop_dec;
		logic       clear_all;
		logic       set_st;
		logic [2:0] st_code;
		logic       cap_kout;
		logic       cap_fidx;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] op;
		logic       key_zero;
		logic       pos_past;
		logic       pos_in_cap;
		logic       cnt_zero;
		logic       full;
		logic       scan_end;
		logic       shift_end;
		logic       match;
	} flags_t;

endpackage

`default_nettype wire

### src/ukos_dpath.sv
// datapath: slot memory, valid bits, count, scan index and result fields
`default_nettype none

module ukos_dpath #(
	parameter int CAPACITY  = 16,
	parameter int KEY_WIDTH = 32
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire ukos_pkg::req_item_t  req,
	input  wire ukos_pkg::cmd_t       cmd,
	output ukos_pkg::flags_t          flags,
	output ukos_pkg::rsp_item_t       res
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 4) ? CW : 4;

	logic [KEY_WIDTH-1:0] mem [CAPACITY];
	logic [CAPACITY-1:0]  valid_q;
	logic [CW-1:0]        count_q;

	logic [2:0]           op_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [3:0]           pos_q;
	logic [CW-1:0]        idx_q;
	logic [2:0]           st_q;
	logic [KEY_WIDTH-1:0] kout_q;
	logic [CW-1:0]        fidx_q;

	logic [KEY_WIDTH-1:0] rd_raw_q;
	logic                 rd_ok_q;
	logic [KEY_WIDTH-1:0] rd_data;

	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        wr_addr;
	logic [AW-1:0]        last_addr;
	logic [KEY_WIDTH-1:0] wr_data;
	logic                 wr_en;

	assign rd_data   = rd_ok_q ? rd_raw_q : '0;
	assign rd_addr   = cmd.rd_next ? AW'(idx_q + CW'(1)) : idx_q[AW-1:0];
	assign last_addr = AW'(count_q - CW'(1));
	assign wr_en     = cmd.sh_wr | cmd.append;
	assign wr_addr   = cmd.append ? count_q[AW-1:0] : idx_q[AW-1:0];
	assign wr_data   = cmd.append ? key_q : rd_data;

	// slot storage, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_raw_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				rd_ok_q <= valid_q[rd_addr];
			end
			if (cmd.clear_all) begin
				valid_q <= '0;
				count_q <= '0;
			end else begin
				if (cmd.append) begin
					valid_q[wr_addr] <= 1'b1;
					count_q          <= count_q + CW'(1);
				end
				if (cmd.sh_wr) begin
					valid_q[wr_addr] <= 1'b1;
				end
				if (cmd.vacate) begin
					valid_q[last_addr] <= 1'b0;
					count_q            <= count_q - CW'(1);
				end
				if (cmd.pop_dec) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	// item fields, scan index and result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= req.op;
			key_q  <= KEY_WIDTH'(req.key);
			pos_q  <= req.position;
			st_q   <= ukos_pkg::ST_OK;
			kout_q <= '0;
			fidx_q <= '0;
		end else begin
			if (cmd.set_st) begin
				st_q <= cmd.st_code;
			end
			if (cmd.cap_kout) begin
				kout_q <= rd_data;
			end
			if (cmd.cap_fidx) begin
				fidx_q <= idx_q;
			end
			if (cmd.append) begin
				fidx_q <= count_q;
			end
		end
		if (cmd.idx_zero) begin
			idx_q <= '0;
		end else if (cmd.idx_pos) begin
			idx_q <= CW'(pos_q);
		end else if (cmd.idx_last) begin
			idx_q <= count_q - CW'(1);
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + CW'(1);
		end
	end

	always_comb begin
		flags.op         = op_q;
		flags.key_zero   = (key_q == '0);
		flags.pos_past   = (PW'(pos_q) >= PW'(count_q));
		flags.pos_in_cap = (PW'(pos_q) < PW'(CAPACITY));
		flags.cnt_zero   = (count_q == '0);
		flags.full       = (count_q == CW'(CAPACITY));
		flags.scan_end   = (idx_q >= count_q);
		flags.shift_end  = ((CW+1)'(idx_q) + (CW+1)'(1) >= (CW+1)'(count_q));
		flags.match      = (rd_data == key_q);
	end

	always_comb begin
		res.status      = st_q;
		res.key_out     = 32'(kout_q);
		res.found_index = 4'(fidx_q);
		res.entry_count = 5'(count_q);
		res.is_empty    = (count_q == '0);
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("count above capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_all |=> (count_q == '0) && (valid_q == '0))
		else $error("clear left entries behind");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |=> count_q == $past(count_q) + CW'(1))
		else $error("append did not grow count");

	a_shrink_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.vacate || cmd.pop_dec) |-> count_q != '0)
		else $error("shrink on empty set");
`endif

endmodule

`default_nettype wire

### src/ukos_ctrl.sv
// controller state machine sequencing scan, fetch and shift steps
`default_nettype none

module ukos_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    req_valid,
	input  wire                    res_free,
	input  wire ukos_pkg::flags_t  flags,
	output ukos_pkg::cmd_t         cmd,
	output logic                   busy,
	output logic                   res_load
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_CMP    = 4'd3;
	localparam logic [3:0] S_FETCH  = 4'd4;
	localparam logic [3:0] S_GRAB   = 4'd5;
	localparam logic [3:0] S_SH_RD  = 4'd6;
	localparam logic [3:0] S_SH_WR  = 4'd7;
	localparam logic [3:0] S_VACATE = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		busy      = (state_q != S_IDLE);
		res_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				state_nxt = S_DONE;
				case (flags.op)
					ukos_pkg::OP_ADD: begin
						if (flags.key_zero) begin
							cmd.set_st  = 1'b1;
							cmd.st_code = ukos_pkg::ST_ZERO;
						end else begin
							cmd.idx_zero = 1'b1;
							state_nxt    = S_SCAN;
						end
					end
					ukos_pkg::OP_FIND, ukos_pkg::OP_REMK: begin
						if (flags.key_zero) begin
							cmd.set_st  = 1'b1;
							cmd.st_code = ukos_pkg::ST_MISS;
						end else begin
							cmd.idx_zero = 1'b1;
							state_nxt    = S_SCAN;
						end
					end
					ukos_pkg::OP_REMI: begin
						if (flags.pos_past) begin
							cmd.set_st  = 1'b1;
							cmd.st_code = ukos_pkg::ST_RANGE;
						end else begin
							cmd.idx_pos = 1'b1;
							state_nxt   = S_FETCH;
						end
					end
					ukos_pkg::OP_POP: begin
						if (flags.cnt_zero) begin
							cmd.set_st  = 1'b1;
							cmd.st_code = ukos_pkg::ST_MISS;
						end else begin
							cmd.idx_last = 1'b1;
							state_nxt    = S_FETCH;
						end
					end
					ukos_pkg::OP_READ: begin
						if (flags.pos_past) begin
							cmd.set_st  = 1'b1;
							cmd.st_code = ukos_pkg::ST_RANGE;
						end
						if (flags.pos_in_cap) begin
							cmd.idx_pos = 1'b1;
							state_nxt   = S_FETCH;
						end
					end
					ukos_pkg::OP_CLEAR: begin
						cmd.clear_all = 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				if (flags.scan_end) begin
					state_nxt  = S_DONE;
					cmd.set_st = 1'b1;
					if (flags.op == ukos_pkg::OP_ADD) begin
						if (flags.full) begin
							cmd.st_code = ukos_pkg::ST_FULL;
						end else begin
							cmd.st_code = ukos_pkg::ST_OK;
							cmd.append  = 1'b1;
						end
					end else begin
						cmd.st_code = ukos_pkg::ST_MISS;
					end
				end else begin
					cmd.rd_en = 1'b1;
					state_nxt = S_CMP;
				end
			end
			S_CMP: begin
				if (flags.match) begin
					cmd.cap_fidx = 1'b1;
					state_nxt    = S_DONE;
					if (flags.op == ukos_pkg::OP_ADD) begin
						cmd.set_st  = 1'b1;
						cmd.st_code = ukos_pkg::ST_DUP;
					end else if (flags.op == ukos_pkg::OP_REMK) begin
						cmd.cap_kout = 1'b1;
						state_nxt    = S_SH_RD;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt   = S_SCAN;
				end
			end
			S_FETCH: begin
				cmd.rd_en = 1'b1;
				state_nxt = S_GRAB;
			end
			S_GRAB: begin
				cmd.cap_kout = 1'b1;
				state_nxt    = S_DONE;
				if (flags.op == ukos_pkg::OP_REMI) begin
					state_nxt = S_SH_RD;
				end else if (flags.op == ukos_pkg::OP_POP) begin
					cmd.pop_dec = 1'b1;
				end
			end
			S_SH_RD: begin
				if (flags.shift_end) begin
					state_nxt = S_VACATE;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_next = 1'b1;
					state_nxt   = S_SH_WR;
				end
			end
			S_SH_WR: begin
				cmd.sh_wr   = 1'b1;
				cmd.idx_inc = 1'b1;
				state_nxt   = S_SH_RD;
			end
			S_VACATE: begin
				cmd.vacate = 1'b1;
				state_nxt  = S_DONE;
			end
			S_DONE: begin
				if (res_free) begin
					res_load  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### src/unique_key_ordered_set.sv
// top level of the unique key ordered set: controller, datapath and result register
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------
//   request | req_valid | req_stall | req (op, key, position)
//   result  | rsp_valid | rsp_stall | rsp (status, key_out, found_index,
//           |           |           |      entry_count, is_empty)
//
// one item at a time; each item is taken, decoded and its result handed over,
// with a scan step and a compare step per slot visited by the key scan and a
// read step and a write step per slot moved by the remove compaction, as the
// slot memory has a single registered read port
// reset clears the count and the per-slot valid bits at once, so all slots
// read as zero right away
// a finished result sits in the output register, and the next item is taken
// while it waits; rsp_stall only holds the controller when that register is full
`default_nettype none

module unique_key_ordered_set #(
	parameter int CAPACITY  = 16,
	parameter int KEY_WIDTH = 32
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       req_valid,
	output logic                      req_stall,
	input  wire ukos_pkg::req_item_t  req,
	output logic                      rsp_valid,
	input  wire                       rsp_stall,
	output ukos_pkg::rsp_item_t       rsp
);

	ukos_pkg::cmd_t      cmd;
	ukos_pkg::flags_t    flags;
	ukos_pkg::rsp_item_t res;
	ukos_pkg::rsp_item_t rsp_q;
	logic                rsp_valid_q;
	logic                busy;
	logic                res_load;
	logic                res_free;

	// output register is free when empty or being taken this cycle
	assign res_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = busy;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	ukos_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.res_free  (res_free),
		.flags     (flags),
		.cmd       (cmd),
		.busy      (busy),
		.res_load  (res_load)
	);

	ukos_dpath #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.flags  (flags),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			rsp_q <= res;
		end
	end

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("second item taken while one is in work");

	a_load_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!rsp_valid_q || !rsp_stall))
		else $error("result written over a waiting item");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> rsp_valid_q)
		else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire
